FILE: rtl/scfs_pkg.sv
// Shared types and constants for the SPI command frame sequencer.
`default_nettype none
package scfs_pkg;

	// Request kinds
	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_DATA   = 1'b1;

	// Slot phases
	localparam logic [1:0] PH_CMD   = 2'd0;
	localparam logic [1:0] PH_ADDR  = 2'd1;
	localparam logic [1:0] PH_DUMMY = 2'd2;
	localparam logic [1:0] PH_DATA  = 2'd3;

	// Data phase directions (anything else acts as full duplex)
	localparam logic [1:0] DIR_READ  = 2'd0;
	localparam logic [1:0] DIR_WRITE = 2'd1;

	// Byte lanes of the 32-bit address
	localparam int ADDR_LANES = 4;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One job handed from the front to the back
	typedef struct packed {
		logic        is_data;      // single data slot
		logic [7:0]  byte_val;     // command byte or data slot byte
		logic        cap;          // capture flag of a data slot
		logic        send_command;
		logic [31:0] address;
		logic [2:0]  nab;          // address slots, already saturated
		logic        lsb_first;
		logic        send_dummy;
		logic        mark_last;    // final slot of the job ends the transaction
	} job_t;

endpackage
`default_nettype wire

FILE: rtl/scfs_req_if.sv
// Request channel: header and data transactions into the sequencer.
`default_nettype none
interface scfs_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  command;
	logic        send_command;
	logic [31:0] address;
	logic [2:0]  address_bytes;
	logic        address_lsb_first;
	logic        send_dummy;
	logic [1:0]  direction;
	logic [15:0] data_length;
	logic [7:0]  data_byte;

	modport source (
		output valid, req_type, command, send_command, address, address_bytes,
		       address_lsb_first, send_dummy, direction, data_length, data_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, command, send_command, address, address_bytes,
		       address_lsb_first, send_dummy, direction, data_length, data_byte,
		output ready
	);
endinterface
`default_nettype wire

FILE: rtl/scfs_slot_if.sv
// Slot channel: byte slots out to the SPI shifter.
`default_nettype none
interface scfs_slot_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       capture;
	logic [1:0] phase;
	logic       last;

	modport source (output valid, tx_byte, capture, phase, last, input ready);
	modport sink   (input valid, tx_byte, capture, phase, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/scfs_front.sv
// Front end: accepts requests, tracks the open transaction, builds jobs.
`default_nettype none
module scfs_front #(
	parameter int MAX_ADDRESS_BYTES = 4,
	parameter int LENGTH_BITS       = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	scfs_req_if.sink           req,
	input  wire logic          q_ready,
	output logic               push,
	output scfs_pkg::job_t     push_job
);
	// Length counter never wider than the 16-bit length field
	localparam int LW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

	logic [LW-1:0] remaining_q;
	logic [1:0]    direction_q;
	logic          open_q;

	logic          accept;
	logic [LW-1:0] hdr_len;
	logic [2:0]    nab_sat;
	logic [LW-1:0] rem_dec;
	logic          data_live;
	logic          hdr_has_slots;

	assign req.ready = q_ready;
	assign accept    = req.valid && req.ready;
	assign hdr_len   = req.data_length[LW-1:0];
	assign rem_dec   = remaining_q - LW'(1);
	assign data_live = open_q && (remaining_q != '0);

	// Address byte count saturates at the configured maximum
	always_comb begin
		if (32'(req.address_bytes) > 32'(MAX_ADDRESS_BYTES)) begin
			nab_sat = 3'(MAX_ADDRESS_BYTES);
		end else begin
			nab_sat = req.address_bytes;
		end
	end

	assign hdr_has_slots = req.send_command || (nab_sat != '0) || req.send_dummy;

	// Job build
	always_comb begin
		push_job              = '0;
		push_job.send_command = req.send_command;
		push_job.address      = req.address;
		push_job.nab          = nab_sat;
		push_job.lsb_first    = req.address_lsb_first;
		push_job.send_dummy   = req.send_dummy;
		if (req.req_type == scfs_pkg::REQ_HEADER) begin
			push_job.is_data   = 1'b0;
			push_job.byte_val  = req.command;
			push_job.cap       = 1'b0;
			push_job.mark_last = (hdr_len == '0);
			push               = accept && hdr_has_slots;
		end else begin
			push_job.is_data   = 1'b1;
			push_job.mark_last = (rem_dec == '0);
			unique case (direction_q)
				scfs_pkg::DIR_READ: begin
					push_job.byte_val = 8'h00;
					push_job.cap      = 1'b1;
				end
				scfs_pkg::DIR_WRITE: begin
					push_job.byte_val = req.data_byte;
					push_job.cap      = 1'b0;
				end
				default: begin
					push_job.byte_val = req.data_byte;
					push_job.cap      = 1'b1;
				end
			endcase
			push = accept && data_live;
		end
	end

	// Transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			direction_q <= '0;
			open_q      <= 1'b0;
		end else if (accept) begin
			if (req.req_type == scfs_pkg::REQ_HEADER) begin
				remaining_q <= hdr_len;
				direction_q <= req.direction;
				open_q      <= (hdr_len != '0);
			end else if (!data_live) begin
				open_q <= 1'b0;
			end else begin
				remaining_q <= rem_dec;
				if (rem_dec == '0) begin
					open_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/scfs_queue.sv
// Short job queue that decouples the front end from the slot sequencer.
`default_nettype none
module scfs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire scfs_pkg::job_t  push_job,
	output logic                 push_ready,
	input  wire logic            pop,
	output logic                 pop_valid,
	output scfs_pkg::job_t       pop_job
);
	scfs_pkg::job_t                      mem [scfs_pkg::QUEUE_DEPTH];
	logic [scfs_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [scfs_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [scfs_pkg::QPTR_W:0]           count_q;

	assign push_ready = (count_q != (scfs_pkg::QPTR_W+1)'(scfs_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (scfs_pkg::QPTR_W)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (scfs_pkg::QPTR_W)'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (scfs_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (scfs_pkg::QPTR_W+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/scfs_back.sv
// Back end: expands queued jobs into byte slots, one slot per cycle unless the slot channel stalls.
`default_nettype none
module scfs_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire scfs_pkg::job_t  q_job,
	output logic                 pop,
	scfs_slot_if.source          slot
);
	scfs_pkg::job_t cur_q;
	logic           cur_valid_q;
	logic [3:0]     pos_q;

	logic       slot_valid_q;
	logic [7:0] tx_q;
	logic       cap_q;
	logic [1:0] phase_q;
	logic       last_q;

	logic [3:0] total;
	logic [3:0] addr_idx;
	logic [2:0] shift_sel;
	logic       is_end;
	logic       emit;
	logic       finish;
	logic [7:0] nx_tx;
	logic       nx_cap;
	logic [1:0] nx_phase;
	logic [7:0] addr_byte;

	assign slot.valid   = slot_valid_q;
	assign slot.tx_byte = tx_q;
	assign slot.capture = cap_q;
	assign slot.phase   = phase_q;
	assign slot.last    = last_q;

	// Slot count of the current job and the end test
	always_comb begin
		if (cur_q.is_data) begin
			total = 4'd1;
		end else begin
			total = 4'(cur_q.send_command) + {1'b0, cur_q.nab} + 4'(cur_q.send_dummy);
		end
		is_end = (pos_q == total - 4'd1);
	end

	assign emit   = cur_valid_q && (!slot_valid_q || slot.ready);
	assign finish = emit && is_end;
	assign pop    = q_valid && (!cur_valid_q || finish);

	// Address byte for this slot
	always_comb begin
		addr_idx = pos_q - 4'(cur_q.send_command);
		if (cur_q.lsb_first) begin
			shift_sel = addr_idx[2:0];
		end else begin
			shift_sel = cur_q.nab - 3'd1 - addr_idx[2:0];
		end
		if (32'(shift_sel) >= scfs_pkg::ADDR_LANES) begin
			addr_byte = 8'h00;
		end else begin
			unique case (shift_sel[1:0])
				2'd0:    addr_byte = cur_q.address[7:0];
				2'd1:    addr_byte = cur_q.address[15:8];
				2'd2:    addr_byte = cur_q.address[23:16];
				default: addr_byte = cur_q.address[31:24];
			endcase
		end
	end

	// Slot contents
	always_comb begin
		nx_cap = 1'b0;
		priority if (cur_q.is_data) begin
			nx_tx    = cur_q.byte_val;
			nx_cap   = cur_q.cap;
			nx_phase = scfs_pkg::PH_DATA;
		end else if (cur_q.send_command && (pos_q == '0)) begin
			nx_tx    = cur_q.byte_val;
			nx_phase = scfs_pkg::PH_CMD;
		end else if (addr_idx < {1'b0, cur_q.nab}) begin
			nx_tx    = addr_byte;
			nx_phase = scfs_pkg::PH_ADDR;
		end else begin
			nx_tx    = 8'h00;
			nx_phase = scfs_pkg::PH_DUMMY;
		end
	end

	// Job register and slot position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			pos_q       <= '0;
		end else if (finish) begin
			cur_valid_q <= 1'b0;
		end else if (emit) begin
			pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_job;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
		end else if (emit) begin
			slot_valid_q <= 1'b1;
		end else if (slot.ready) begin
			slot_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_q    <= nx_tx;
			cap_q   <= nx_cap;
			phase_q <= nx_phase;
			last_q  <= is_end && cur_q.mark_last;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/spi_command_frame_sequencer.sv
// Top level of the SPI command frame sequencer.
// Header transactions expand into command, address and dummy byte slots; data
// transactions give one data slot each while a transaction is open, and are
// dropped otherwise. The front end takes one request transaction per cycle
// as long as its four-entry job queue has room; the back end emits one byte
// slot per cycle into a registered output while the slot channel does not
// stall, so a header with command, four address bytes and dummy gives six
// slots and a data transaction gives one. Slots leave in request order with
// the last slot of a transaction marked.
`default_nettype none
module spi_command_frame_sequencer #(
	parameter int MAX_ADDRESS_BYTES = 4,
	parameter int LENGTH_BITS       = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	scfs_req_if.sink    req,
	scfs_slot_if.source slot
);
	logic           push;
	logic           push_ready;
	scfs_pkg::job_t push_job;
	logic           pop;
	logic           pop_valid;
	scfs_pkg::job_t pop_job;

	scfs_front #(
		.MAX_ADDRESS_BYTES (MAX_ADDRESS_BYTES),
		.LENGTH_BITS       (LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_ready  (push_ready),
		.push     (push),
		.push_job (push_job)
	);

	scfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	scfs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_job   (pop_job),
		.pop     (pop),
		.slot    (slot)
	);
endmodule
`default_nettype wire

FILE: bench/slot_frame_checker.sv
// Checker: watches both channels, predicts the byte slots of each request and compares them.
module slot_frame_checker #(
	parameter int MAX_ADDRESS_BYTES = 4,
	parameter int LENGTH_BITS       = 16
) (
	input  logic clk,
	input  logic arst_n,
	scfs_req_if  req,
	scfs_slot_if slot,
	output int   fail_count,
	output int   pending
);

	localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       capture;
		logic [1:0] phase;
		logic       last;
	} slot_t;

	slot_t       owed_slots[$];
	logic [31:0] data_left;
	logic [1:0]  data_dir;
	logic        txn_open;

	// Turn one accepted request transaction into the slots it owes
	function automatic void expand_request();
		slot_t       frame[MAX_ADDRESS_BYTES + 2];
		slot_t       one;
		int          n;
		int          nab;
		int          sh;
		logic [31:0] len;
		n = 0;
		if (req.req_type == scfs_pkg::REQ_HEADER) begin
			nab = (int'(req.address_bytes) > MAX_ADDRESS_BYTES) ?
				MAX_ADDRESS_BYTES : int'(req.address_bytes);
			len = 32'(req.data_length) & LEN_MASK;
			if (req.send_command) begin
				frame[n] = {req.command, 1'b0, scfs_pkg::PH_CMD, 1'b0};
				n++;
			end
			// lanes beyond the 32-bit address shift out as zero
			for (int i = 0; i < nab; i++) begin
				sh = req.address_lsb_first ? i : nab - 1 - i;
				frame[n] = {8'(req.address >> (8 * sh)), 1'b0, scfs_pkg::PH_ADDR, 1'b0};
				n++;
			end
			if (req.send_dummy) begin
				frame[n] = {8'h00, 1'b0, scfs_pkg::PH_DUMMY, 1'b0};
				n++;
			end
			// a new header always replaces whatever was open
			data_dir  = req.direction;
			data_left = len;
			txn_open  = (len != 0);
			if (len == 0 && n > 0)
				frame[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++)
				owed_slots.push_back(frame[i]);
		end else if (txn_open && data_left != 0) begin
			case (data_dir)
				scfs_pkg::DIR_READ:  one = {8'h00, 1'b1, scfs_pkg::PH_DATA, 1'b0};
				scfs_pkg::DIR_WRITE: one = {req.data_byte, 1'b0, scfs_pkg::PH_DATA, 1'b0};
				default:             one = {req.data_byte, 1'b1, scfs_pkg::PH_DATA, 1'b0};
			endcase
			data_left = (data_left - 32'd1) & LEN_MASK;
			if (data_left == 0) begin
				one.last = 1'b1;
				txn_open = 1'b0;
			end
			owed_slots.push_back(one);
		end else begin
			// stray data byte: dropped
			txn_open = 1'b0;
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: slot %s mismatch: expected %0h, actual %0h",
				$time, name, want, got);
		end
	endfunction

	// Predict on accepted requests, compare on accepted slots
	always @(posedge clk or negedge arst_n) begin
		slot_t want;
		if (!arst_n) begin
			owed_slots.delete();
			data_left = '0;
			data_dir  = scfs_pkg::DIR_READ;
			txn_open  = 1'b0;
		end else begin
			if (req.valid && req.ready)
				expand_request();
			if (slot.valid && slot.ready) begin
				if (owed_slots.size() == 0) begin
					fail_count++;
					$display({"%0t: unexpected slot: expected none, ",
						"actual tx_byte=%0h capture=%0b phase=%0d last=%0b"},
						$time, slot.tx_byte, slot.capture, slot.phase, slot.last);
				end else begin
					want = owed_slots.pop_front();
					check_field("tx_byte", want.tx_byte, slot.tx_byte);
					check_field("capture", want.capture, slot.capture);
					check_field("phase", want.phase, slot.phase);
					check_field("last", want.last, slot.last);
				end
			end
		end
		pending = owed_slots.size();
	end

endmodule

FILE: bench/tb.sv
// Testbench top: clock, reset, request and slot traffic, and the final verdict.
module tb;

	localparam logic [1:0] DIR_READ     = scfs_pkg::DIR_READ;
	localparam logic [1:0] DIR_WRITE    = scfs_pkg::DIR_WRITE;
	localparam logic [1:0] DIR_DUPLEX   = 2'd2;
	localparam logic [1:0] DIR_SPARE    = 2'd3;
	localparam int         RX_LONG_HOLD = 300;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         RANDOM_ITEMS = 90;
	localparam int         DRAIN_CYCLES = 20;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  command;
		logic        send_command;
		logic [31:0] address;
		logic [2:0]  address_bytes;
		logic        address_lsb_first;
		logic        send_dummy;
		logic [1:0]  direction;
		logic [15:0] data_length;
		logic [7:0]  data_byte;
	} req_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycles;
	bit   tx_idle;
	bit   rx_idle;
	bit   rx_hold;

	scfs_req_if  req_ch();
	scfs_slot_if slot_ch();

	spi_command_frame_sequencer dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .slot(slot_ch)
	);

	slot_frame_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .slot(slot_ch),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic drive(input req_item_t r);
		req_ch.req_type          <= r.req_type;
		req_ch.command           <= r.command;
		req_ch.send_command      <= r.send_command;
		req_ch.address           <= r.address;
		req_ch.address_bytes     <= r.address_bytes;
		req_ch.address_lsb_first <= r.address_lsb_first;
		req_ch.send_dummy        <= r.send_dummy;
		req_ch.direction         <= r.direction;
		req_ch.data_length       <= r.data_length;
		req_ch.data_byte         <= r.data_byte;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance,
	// valid still high so a back-to-back transaction needs no toggle
	task automatic send(input req_item_t r);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		drive(r);
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Every field random; unused ones still toggle
	function automatic req_item_t random_fields();
		req_item_t r;
		r.req_type          = 1'($urandom_range(0, 1));
		r.command           = 8'($urandom);
		r.send_command      = 1'($urandom_range(0, 1));
		r.address           = $urandom;
		r.address_bytes     = 3'($urandom_range(0, 7));
		r.address_lsb_first = 1'($urandom_range(0, 1));
		r.send_dummy        = 1'($urandom_range(0, 1));
		r.direction         = 2'($urandom_range(0, 3));
		r.data_length       = 16'($urandom);
		r.data_byte         = 8'($urandom);
		return r;
	endfunction

	function automatic req_item_t header(input logic [7:0] cmd, input logic sc,
			input logic [31:0] addr, input logic [2:0] nab, input logic lsb,
			input logic dummy, input logic [1:0] dir, input logic [15:0] len);
		req_item_t r;
		r                   = random_fields();
		r.req_type          = scfs_pkg::REQ_HEADER;
		r.command           = cmd;
		r.send_command      = sc;
		r.address           = addr;
		r.address_bytes     = nab;
		r.address_lsb_first = lsb;
		r.send_dummy        = dummy;
		r.direction         = dir;
		r.data_length       = len;
		return r;
	endfunction

	function automatic req_item_t data_item(input logic [7:0] b);
		req_item_t r;
		r           = random_fields();
		r.req_type  = scfs_pkg::REQ_DATA;
		r.data_byte = b;
		return r;
	endfunction

	// Slot receiver: random stalls, quiet stretches, and one long hold-off
	initial begin
		int stall;
		stall = 0;
		slot_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				slot_ch.ready <= 1'b0;
				repeat (RX_LONG_HOLD) @(negedge clk);
				rx_hold = 1'b0;
			end
			if (stall > 0) begin
				slot_ch.ready <= 1'b0;
				stall--;
			end else begin
				slot_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (slot_ch.valid && slot_ch.ready) begin
				if ($urandom_range(0, 19) == 0)
					rx_idle = !rx_idle;
				stall = rx_idle ? $urandom_range(0, 8) : 0;
			end
		end
	end

	// Request stimulus and verdict
	initial begin
		req_item_t hdr;
		int        useful;
		int        seq;
		int        pick;
		int        nd;
		int        extra;
		req_ch.valid <= 1'b0;
		drive('0);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: stray data, extremes, every direction, saturation, abandon
		send(data_item(8'h3C));
		send(header(8'hFF, 1'b1, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b1, DIR_READ, 16'd2));
		send(data_item(8'hFF));
		send(data_item(8'h00));
		send(header(8'h00, 1'b0, 32'h1234_5678, 3'd3, 1'b1, 1'b0, DIR_WRITE, 16'd1));
		send(data_item(8'hA5));
		send(header(8'h00, 1'b1, 32'h8765_4321, 3'd7, 1'b1, 1'b1, DIR_DUPLEX, 16'd1));
		send(data_item(8'h5A));
		send(header(8'h9F, 1'b0, 32'h0000_0000, 3'd0, 1'b0, 1'b0, DIR_SPARE, 16'd2));
		send(data_item(8'h81));
		send(data_item(8'h7E));
		send(data_item(8'hC3));
		send(header(8'h0B, 1'b1, 32'h00AB_CDEF, 3'd2, 1'b0, 1'b0, DIR_WRITE, 16'd0));
		send(header(8'h00, 1'b0, 32'hDEAD_BEEF, 3'd0, 1'b0, 1'b0, DIR_READ, 16'd0));
		send(header(8'h00, 1'b0, 32'h0000_0000, 3'd0, 1'b0, 1'b1, DIR_READ, 16'd0));
		send(header(8'h02, 1'b0, 32'hC0FF_EE00, 3'd1, 1'b1, 1'b0, DIR_WRITE, 16'hFFFF));
		send(data_item(8'h11));
		send(data_item(8'hEE));
		send(header(8'h03, 1'b1, 32'h0000_0100, 3'd5, 1'b0, 1'b1, DIR_READ, 16'd1));
		send(data_item(8'h77));
		send(header(8'hAA, 1'b1, 32'h5555_AAAA, 3'd6, 1'b0, 1'b0, DIR_DUPLEX, 16'd0));

		// Random: mostly well-formed transactions, some cut short, some overrun,
		// a little stray noise; the first stretch runs flat out into a held receiver
		rx_hold = 1'b1;
		useful  = 0;
		seq     = 0;
		while (useful < RANDOM_ITEMS) begin
			tx_idle = (seq < 10) ? 1'b0 : ($urandom_range(0, 3) != 0);
			pick    = $urandom_range(0, 99);
			if (pick < 90) begin
				hdr          = random_fields();
				hdr.req_type = scfs_pkg::REQ_HEADER;
				if ($urandom_range(0, 15) == 0)
					hdr.data_length = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
				else
					hdr.data_length = 16'($urandom_range(0, 5));
				send(hdr);
				useful++;
				nd = (hdr.data_length > 6) ? $urandom_range(1, 4) : int'(hdr.data_length);
				extra = 0;
				if (pick >= 70 && pick < 80 && nd > 0)
					nd = $urandom_range(0, nd - 1);
				else if (pick >= 80 && hdr.data_length <= 6)
					extra = $urandom_range(1, 2);
				repeat (nd) begin
					send(data_item(8'($urandom)));
					useful++;
				end
				repeat (extra)
					send(data_item(8'($urandom)));
			end else begin
				send(data_item(8'($urandom)));
			end
			seq++;
		end
		req_ch.valid <= 1'b0;

		// Drain
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
